// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high
`define DQHNP_AST_IMP(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("dqhnp check failed");

// Next-cycle implication, sampled on clk, off while rst is high
`define DQHNP_AST_NXT(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("dqhnp check failed");

`endif

// ----- rtl/dqhnp_pkg.sv -----
package dqhnp_pkg;

  // Header length in bytes and the longest name in wire bytes
  localparam int HDR_LEN         = 12;
  localparam int MAX_NAME_LENGTH = 255;
  // Length bytes above this value are pointers or reserved label types
  localparam int MAX_LABEL_LEN   = 63;
  // Type and class bytes after each question name
  localparam int TAIL_LEN        = 4;
  localparam logic [7:0] DOT_CHAR = 8'h2E;

  // Result queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Register map
  localparam logic [1:0] ADDR_PARSE_Q = 2'd0;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HEADER = 3'd1,
    PH_LEN    = 3'd2,
    PH_CHARS  = 3'd3,
    PH_TAIL   = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    KIND_HEADER   = 3'd0,
    KIND_CHAR     = 3'd1,
    KIND_NAME_END = 3'd2,
    KIND_SHORT    = 3'd3,
    KIND_POINTER  = 3'd4,
    KIND_TOO_LONG = 3'd5
  } kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_start;
    logic       packet_end;
  } request_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [15:0] message_id;
    logic [3:0]  opcode_field;
    logic [4:0]  flag_bits;
    logic [2:0]  reserved_z;
    logic [3:0]  response_code;
    logic [15:0] question_count;
    logic [15:0] answer_count;
    logic [15:0] authority_count;
    logic [15:0] additional_count;
    logic [7:0]  name_char;
    logic        end_of_message;
  } result_t;

  // Results of one processed byte, handed from parser to queue
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  function automatic result_t simple_result(kind_t kind, logic [7:0] ch, logic eom);
    result_t r;
    r                = '0;
    r.result_kind    = kind;
    r.name_char      = ch;
    r.end_of_message = eom;
    return r;
  endfunction

  function automatic result_t header_result(logic [HDR_LEN-1:0][7:0] hb, logic eom);
    result_t r;
    r                  = '0;
    r.result_kind      = KIND_HEADER;
    r.message_id       = {hb[0], hb[1]};
    r.opcode_field     = hb[2][6:3];
    r.flag_bits        = {hb[2][7], hb[2][2], hb[2][1], hb[2][0], hb[3][7]};
    r.reserved_z       = hb[3][6:4];
    r.response_code    = hb[3][3:0];
    r.question_count   = {hb[4], hb[5]};
    r.answer_count     = {hb[6], hb[7]};
    r.authority_count  = {hb[8], hb[9]};
    r.additional_count = {hb[10], hb[11]};
    r.end_of_message   = eom;
    return r;
  endfunction

endpackage

// ----- rtl/dqhnp_parser.sv -----
module dqhnp_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               parse_questions,
  input  logic               req_valid,
  output logic               req_stall,
  input  dqhnp_pkg::request_t req,
  input  logic               room,
  output dqhnp_pkg::push_t   push
);
  import dqhnp_pkg::*;

  // Input register
  logic     held_valid;
  request_t held;
  logic     proc;
  logic     accept;

  // Parse state
  phase_t                   phase, phase_next;
  logic [HDR_LEN-1:0][7:0]  header_bytes;
  logic [3:0]               header_index, header_index_next;
  logic [5:0]               label_remaining, label_remaining_next;
  logic [15:0]              questions_left, questions_left_next;
  logic [2:0]               tail_skip, tail_skip_next;
  logic [7:0]               name_length, name_length_next;
  logic                     first_label, first_label_next;

  // Work signals
  phase_t                   phase_now;
  logic [3:0]               idx_now;
  logic [3:0]               idx_inc;
  logic                     hdr_we;
  logic [7:0]               d;
  logic [8:0]               nl;
  logic [15:0]              q_hdr;
  logic [15:0]              ql_dec;
  logic [5:0]               lr_dec;
  logic [2:0]               ts_dec;
  logic [HDR_LEN-1:0][7:0]  hdr_now;

  // Process the held byte only when the queue can take two results
  assign proc      = held_valid && room;
  assign req_stall = held_valid && !room;
  assign accept    = req_valid && !req_stall;

  // Hold the accepted request until processed
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (proc) begin
      held_valid <= 1'b0;
    end
    if (accept) begin
      held <= req;
    end
  end

  // Advance parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      header_index    <= '0;
      label_remaining <= '0;
      questions_left  <= '0;
      tail_skip       <= '0;
      name_length     <= '0;
      first_label     <= 1'b1;
    end else begin
      phase           <= phase_next;
      header_index    <= header_index_next;
      label_remaining <= label_remaining_next;
      questions_left  <= questions_left_next;
      tail_skip       <= tail_skip_next;
      name_length     <= name_length_next;
      first_label     <= first_label_next;
    end
  end

  // Capture header bytes
  always_ff @(posedge clk) begin
    if (hdr_we) begin
      header_bytes[idx_now] <= d;
    end
  end

  assign d       = held.data_byte;
  assign idx_inc = idx_now + 4'd1;
  assign nl      = 9'(name_length) + 9'(d[5:0]) + 9'd1;
  assign q_hdr   = {header_bytes[4], header_bytes[5]};
  assign ql_dec  = questions_left - 16'd1;
  assign lr_dec  = label_remaining - 6'd1;
  assign ts_dec  = tail_skip - 3'd1;

  // Header view with the last byte taken straight from the input
  always_comb begin
    hdr_now                = header_bytes;
    hdr_now[HDR_LEN-1]     = d;
  end

  // Decode one byte into next state and up to two results
  always_comb begin
    phase_next           = phase;
    header_index_next    = header_index;
    label_remaining_next = label_remaining;
    questions_left_next  = questions_left;
    tail_skip_next       = tail_skip;
    name_length_next     = name_length;
    first_label_next     = first_label;
    hdr_we               = 1'b0;
    push                 = '0;
    phase_now            = held.packet_start ? PH_HEADER : phase;
    idx_now              = held.packet_start ? 4'd0 : header_index;

    if (proc) begin
      phase_next = phase_now;
      unique case (phase_now)
        PH_HEADER: begin
          hdr_we            = 1'b1;
          header_index_next = idx_inc;
          if (idx_inc == 4'(HDR_LEN)) begin
            push.count = 2'd1;
            if (!parse_questions || q_hdr == 16'd0) begin
              push.first = header_result(hdr_now, 1'b1);
              phase_next = PH_IDLE;
            end else begin
              push.first          = header_result(hdr_now, 1'b0);
              questions_left_next = q_hdr;
              name_length_next    = '0;
              first_label_next    = 1'b1;
              phase_next          = PH_LEN;
            end
          end
        end
        PH_LEN: begin
          push.count = 2'd1;
          if (d == 8'd0) begin
            questions_left_next = ql_dec;
            push.first          = simple_result(KIND_NAME_END, 8'd0, ql_dec == 16'd0);
            name_length_next    = (name_length == 8'hFF) ? 8'hFF : name_length + 8'd1;
            tail_skip_next      = 3'(TAIL_LEN);
            phase_next          = PH_TAIL;
          end else if (d > 8'(MAX_LABEL_LEN)) begin
            push.first = simple_result(KIND_POINTER, 8'd0, 1'b1);
            phase_next = PH_IDLE;
          end else if (nl >= 9'(MAX_NAME_LENGTH)) begin
            push.first       = simple_result(KIND_TOO_LONG, 8'd0, 1'b1);
            name_length_next = (nl > 9'd255) ? 8'hFF : nl[7:0];
            phase_next       = PH_IDLE;
          end else begin
            name_length_next     = nl[7:0];
            push.count           = first_label ? 2'd0 : 2'd1;
            push.first           = simple_result(KIND_CHAR, DOT_CHAR, 1'b0);
            first_label_next     = 1'b0;
            label_remaining_next = d[5:0];
            phase_next           = PH_CHARS;
          end
        end
        PH_CHARS: begin
          push.count           = 2'd1;
          push.first           = simple_result(KIND_CHAR, d, 1'b0);
          label_remaining_next = lr_dec;
          if (lr_dec == 6'd0) begin
            phase_next = PH_LEN;
          end
        end
        PH_TAIL: begin
          tail_skip_next = ts_dec;
          if (ts_dec == 3'd0) begin
            if (questions_left == 16'd0) begin
              phase_next = PH_IDLE;
            end else begin
              name_length_next = '0;
              first_label_next = 1'b1;
              phase_next       = PH_LEN;
            end
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase

      // Close a message that ends while more bytes are expected
      if (held.packet_end && phase_next != PH_IDLE) begin
        if (push.count == 2'd0) begin
          push.first = simple_result(KIND_SHORT, 8'd0, 1'b1);
        end else begin
          push.second = simple_result(KIND_SHORT, 8'd0, 1'b1);
        end
        push.count = push.count + 2'd1;
        phase_next = PH_IDLE;
      end
    end
  end

endmodule

// ----- rtl/dqhnp_outq.sv -----
module dqhnp_outq (
  input  logic              clk,
  input  logic              rst,
  input  dqhnp_pkg::push_t  push,
  output logic              room,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output dqhnp_pkg::result_t rsp
);
  import dqhnp_pkg::*;

  result_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                pop;

  assign rsp_valid = count != '0;
  assign rsp       = slots[rd_ptr];
  assign pop       = rsp_valid && !rsp_stall;
  // Room for the two results a single byte can produce
  assign room      = count <= QCNT_W'(QUEUE_DEPTH - 2);

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.count);
      rd_ptr <= rd_ptr + QPTR_W'(pop);
      count  <= count + QCNT_W'(push.count) - QCNT_W'(pop);
    end
  end

  // Write up to two results per cycle
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      slots[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      slots[wr_ptr + QPTR_W'(1)] <= push.second;
    end
  end

endmodule

// ----- rtl/dns_query_header_name_parser.sv -----
// Channel   | Direction | Payload                         | Handshake
// ----------+-----------+---------------------------------+-------------------------
// req       | in        | one message byte + start/end    | req_valid / req_stall
// rsp       | out       | header, name char or status     | rsp_valid / rsp_stall
// APB       | in        | parse_questions at address 0    | psel / penable / pready
//
// One byte is taken every cycle while the result queue has room for two results;
// each byte waits in an input register and its results are written into the queue.
// A byte that gives two results (a result followed by the short-packet close)
// occupies the single result port for both, so the four-entry result queue
// sets the sustained rate when such bytes cluster or when rsp_stall is held.
// Reset is synchronous; it drops any message in progress and sets parse_questions.
// req_stall rises only while the result queue holds more than two results.
module dns_query_header_name_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  dqhnp_pkg::request_t req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output dqhnp_pkg::result_t  rsp,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [1:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import dqhnp_pkg::*;

  logic    parse_questions;
  logic    room;
  push_t   push;

  assign pready = 1'b1;
  assign prdata = {31'd0, parse_questions};

  // Write the configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_questions <= 1'b1;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_PARSE_Q) begin
      parse_questions <= pwdata[0];
    end
  end

  dqhnp_parser u_parser (
    .clk             (clk),
    .rst             (rst),
    .parse_questions (parse_questions),
    .req_valid       (req_valid),
    .req_stall       (req_stall),
    .req             (req),
    .room            (room),
    .push            (push)
  );

  dqhnp_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// ----- rtl/dqhnp_checker.sv -----
`include "assert_macros.svh"

module dqhnp_checker (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_stall,
  input logic                rsp_valid,
  input logic                rsp_stall,
  input dqhnp_pkg::result_t  rsp,
  input logic [31:0]         prdata
);
  import dqhnp_pkg::*;

  // A stalled result stays valid and unchanged
  `DQHNP_AST_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

  // Reset leaves the result side empty and the request side open
  `DQHNP_AST_IMP(a_reset_empty, $past(rst), !rsp_valid && !req_stall)

  // Requests back up only behind queued results
  `DQHNP_AST_IMP(a_stall_has_rsp, req_stall, rsp_valid)

  // Question parsing is on after reset
  `DQHNP_AST_IMP(a_reset_cfg, $past(rst), prdata[0] == 1'b1)

endmodule

bind dns_query_header_name_parser dqhnp_checker u_dqhnp_checker (.*);

// ----- verif/tb_dns_query_header_name_parser.sv -----
// Tracks the parser state and holds the results each accepted byte should produce
class dns_result_board;
  dqhnp_pkg::phase_t  phase;
  logic [7:0]         hdr [dqhnp_pkg::HDR_LEN];
  logic [3:0]         hdr_index;
  logic [7:0]         label_left;
  logic [15:0]        questions_left;
  logic [2:0]         tail_left;
  logic [7:0]         name_len;
  logic               first_label;
  logic               walk_names;
  dqhnp_pkg::result_t pending_results[$];
  int                 mismatches;
  int                 bytes_parsed;
  int                 results_checked;
  int                 kind_seen[6];

  function new();
    phase          = dqhnp_pkg::PH_IDLE;
    hdr_index      = '0;
    label_left     = '0;
    questions_left = '0;
    tail_left      = '0;
    name_len       = '0;
    first_label    = 1'b1;
    walk_names     = 1'b1;
    mismatches      = 0;
    bytes_parsed    = 0;
    results_checked = 0;
    foreach (hdr[i]) hdr[i] = '0;
    foreach (kind_seen[i]) kind_seen[i] = 0;
  endfunction

  function void set_walk_names(logic value);
    walk_names = value;
  endfunction

  // Queue one result behind those already pending
  function void add_pending(dqhnp_pkg::result_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  function dqhnp_pkg::result_t plain_result(dqhnp_pkg::kind_t kind, logic [7:0] ch, logic eom);
    dqhnp_pkg::result_t r;
    r                = '0;
    r.result_kind    = kind;
    r.name_char      = ch;
    r.end_of_message = eom;
    return r;
  endfunction

  // Unpack the twelve collected header bytes
  function dqhnp_pkg::result_t header_fields(logic eom);
    dqhnp_pkg::result_t r;
    r                  = '0;
    r.result_kind      = dqhnp_pkg::KIND_HEADER;
    r.message_id       = {hdr[0], hdr[1]};
    r.opcode_field     = hdr[2][6:3];
    r.flag_bits[4]     = hdr[2][7];
    r.flag_bits[3]     = hdr[2][2];
    r.flag_bits[2]     = hdr[2][1];
    r.flag_bits[1]     = hdr[2][0];
    r.flag_bits[0]     = hdr[3][7];
    r.reserved_z       = hdr[3][6:4];
    r.response_code    = hdr[3][3:0];
    r.question_count   = {hdr[4], hdr[5]};
    r.answer_count     = {hdr[6], hdr[7]};
    r.authority_count  = {hdr[8], hdr[9]};
    r.additional_count = {hdr[10], hdr[11]};
    r.end_of_message   = eom;
    return r;
  endfunction

  // Advance the parser by one accepted request and queue what it emits
  function void note_byte(dqhnp_pkg::request_t r);
    logic [7:0] d;
    logic [9:0] span;
    d = r.data_byte;
    if (r.packet_start) begin
      phase     = dqhnp_pkg::PH_HEADER;
      hdr_index = '0;
    end
    if (phase != dqhnp_pkg::PH_IDLE) bytes_parsed++;
    case (phase)
      dqhnp_pkg::PH_HEADER: begin
        if (hdr_index < dqhnp_pkg::HDR_LEN) hdr[hdr_index] = d;
        hdr_index = hdr_index + 4'd1;
        if (hdr_index >= dqhnp_pkg::HDR_LEN) begin
          if (!walk_names || {hdr[4], hdr[5]} == 16'd0) begin
            add_pending(header_fields(1'b1));
            phase = dqhnp_pkg::PH_IDLE;
          end else begin
            add_pending(header_fields(1'b0));
            questions_left = {hdr[4], hdr[5]};
            name_len       = '0;
            first_label    = 1'b1;
            phase          = dqhnp_pkg::PH_LEN;
          end
        end
      end
      dqhnp_pkg::PH_LEN: begin
        if (d == 8'd0) begin
          questions_left = questions_left - 16'd1;
          add_pending(plain_result(dqhnp_pkg::KIND_NAME_END, 8'd0,
                                   questions_left == 16'd0));
          if (name_len != 8'hFF) name_len = name_len + 8'd1;
          tail_left = 3'(dqhnp_pkg::TAIL_LEN);
          phase     = dqhnp_pkg::PH_TAIL;
        end else if (d > dqhnp_pkg::MAX_LABEL_LEN) begin
          add_pending(plain_result(dqhnp_pkg::KIND_POINTER, 8'd0, 1'b1));
          phase = dqhnp_pkg::PH_IDLE;
        end else begin
          // Name length counts the length byte and the characters
          span = 10'(name_len) + 10'(d) + 10'd1;
          if (span + 10'd1 > dqhnp_pkg::MAX_NAME_LENGTH) begin
            add_pending(plain_result(dqhnp_pkg::KIND_TOO_LONG, 8'd0, 1'b1));
            name_len = (span > 10'd255) ? 8'hFF : span[7:0];
            phase    = dqhnp_pkg::PH_IDLE;
          end else begin
            name_len = span[7:0];
            if (!first_label) begin
              add_pending(plain_result(dqhnp_pkg::KIND_CHAR, dqhnp_pkg::DOT_CHAR, 1'b0));
            end
            first_label = 1'b0;
            label_left  = d;
            phase       = dqhnp_pkg::PH_CHARS;
          end
        end
      end
      dqhnp_pkg::PH_CHARS: begin
        add_pending(plain_result(dqhnp_pkg::KIND_CHAR, d, 1'b0));
        label_left = label_left - 8'd1;
        if (label_left == 8'd0) phase = dqhnp_pkg::PH_LEN;
      end
      dqhnp_pkg::PH_TAIL: begin
        tail_left = tail_left - 3'd1;
        if (tail_left == 3'd0) begin
          if (questions_left == 16'd0) begin
            phase = dqhnp_pkg::PH_IDLE;
          end else begin
            name_len    = '0;
            first_label = 1'b1;
            phase       = dqhnp_pkg::PH_LEN;
          end
        end
      end
      default: begin
        phase = dqhnp_pkg::PH_IDLE;
      end
    endcase
    // Close an unfinished message on its last byte
    if (r.packet_end && phase != dqhnp_pkg::PH_IDLE) begin
      add_pending(plain_result(dqhnp_pkg::KIND_SHORT, 8'd0, 1'b1));
      phase = dqhnp_pkg::PH_IDLE;
    end
  endfunction

  function void flag_mismatch(string what, dqhnp_pkg::result_t want, dqhnp_pkg::result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch %0d:%s", mismatches, what);
      $display("  expected kind %0d eom %0d char %h all %h", want.result_kind,
               want.end_of_message, want.name_char, want);
      $display("  actual   kind %0d eom %0d char %h all %h", got.result_kind,
               got.end_of_message, got.name_char, got);
    end
  endfunction

  // Compare one accepted result with the oldest pending one
  function void check_result(dqhnp_pkg::result_t got);
    dqhnp_pkg::result_t want;
    string              diff;
    results_checked++;
    if (got.result_kind < 6) kind_seen[got.result_kind]++;
    if (pending_results.size() == 0) begin
      flag_mismatch(" result with nothing pending", '0, got);
      return;
    end
    want = pending_results.pop_front();
    diff = "";
    if (got.result_kind != want.result_kind) diff = {diff, " result_kind"};
    if (got.message_id != want.message_id) diff = {diff, " message_id"};
    if (got.opcode_field != want.opcode_field) diff = {diff, " opcode_field"};
    if (got.flag_bits != want.flag_bits) diff = {diff, " flag_bits"};
    if (got.reserved_z != want.reserved_z) diff = {diff, " reserved_z"};
    if (got.response_code != want.response_code) diff = {diff, " response_code"};
    if (got.question_count != want.question_count) diff = {diff, " question_count"};
    if (got.answer_count != want.answer_count) diff = {diff, " answer_count"};
    if (got.authority_count != want.authority_count) diff = {diff, " authority_count"};
    if (got.additional_count != want.additional_count) diff = {diff, " additional_count"};
    if (got.name_char != want.name_char) diff = {diff, " name_char"};
    if (got.end_of_message != want.end_of_message) diff = {diff, " end_of_message"};
    if (diff != "") flag_mismatch(diff, want, got);
  endfunction
endclass

module tb_dns_query_header_name_parser;
  timeunit 1ns;
  timeprecision 1ps;
  import dqhnp_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 12;

  typedef enum int {
    MSG_CLEAN,
    MSG_TRUNCATED,
    MSG_RESTART,
    MSG_POINTER,
    MSG_TOO_LONG
  } msg_shape_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  request_t    req;
  logic        rsp_valid;
  logic        rsp_stall;
  result_t     rsp;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  dns_result_board board;
  logic [7:0]      frame[$];
  bit              send_quiet;
  bit              rcv_quiet;
  bit              long_hold_armed;
  int              long_holds_done;
  int              messages_sent;
  int              bytes_sent;
  int              cycle_count;
  bit              phase_setting[4] = '{1'b0, 1'b1, 1'b0, 1'b1};
  int              phase_budget[4]  = '{90, 210, 70, 180};

  dns_query_header_name_parser dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Check every accepted result
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) board.check_result(rsp);
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still pending", cycle_count,
             board.pending_results.size());
    $display("tb_dns_query_header_name_parser: FAIL");
    $finish;
  end

  // Receiver: random stall before each result, quiet stretches, and long holds on request
  initial begin
    int hold;
    forever begin
      if ($urandom_range(0, 31) == 0) rcv_quiet = !rcv_quiet;
      hold = rcv_quiet ? 0 : $urandom_range(0, 8);
      if (long_hold_armed) begin
        hold            = LONG_HOLD;
        long_hold_armed = 1'b0;
        long_holds_done++;
      end
      if (hold > 0) begin
        rsp_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      @(posedge clk);
      while (!rsp_valid) @(posedge clk);
    end
  end

  // Offer one request after a random gap and hold it until taken
  task automatic send_byte(input logic [7:0] data, input logic start, input logic last);
    request_t r;
    int       gap;
    r.data_byte    = data;
    r.packet_start = start;
    r.packet_end   = last;
    gap = send_quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    bytes_sent++;
    board.note_byte(r);
  endtask

  // Send the built frame; end_at marks the byte carrying packet_end, -1 for none
  task automatic send_frame(input int end_at);
    messages_sent++;
    foreach (frame[i]) send_byte(frame[i], i == 0, i == end_at);
  endtask

  // Drop valid and let every pending result drain
  task automatic settle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_parse_questions(input logic value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_PARSE_Q;
    pwdata  <= {31'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.set_walk_names(value);
  endtask

  // Append one byte to the frame under construction
  function automatic void put_byte(logic [7:0] value);
    frame.insert(frame.size(), value);
  endfunction

  function automatic void put_fill(logic [7:0] value, int count);
    repeat (count) put_byte(value);
  endfunction

  function automatic void put_header(logic [15:0] qd);
    repeat (4) put_byte(8'($urandom));
    put_byte(qd[15:8]);
    put_byte(qd[7:0]);
    repeat (6) put_byte(8'($urandom));
  endfunction

  function automatic void put_label(int len);
    put_byte(8'(len));
    repeat (len) put_byte(8'($urandom));
  endfunction

  function automatic void put_name_end();
    put_byte(8'h00);
    repeat (TAIL_LEN) put_byte(8'($urandom));
  endfunction

  // Build and send one mostly well-formed message
  task automatic send_random_message();
    msg_shape_t  shape;
    logic [15:0] qd;
    int          pick;
    int          nq;
    int          labels;
    int          end_at;
    int          cut;
    pick = $urandom_range(0, 99);
    if (pick < 60) shape = MSG_CLEAN;
    else if (pick < 75) shape = MSG_TRUNCATED;
    else if (pick < 86) shape = MSG_RESTART;
    else if (pick < 97) shape = MSG_POINTER;
    else shape = MSG_TOO_LONG;
    pick = $urandom_range(0, 19);
    if (pick == 0) qd = 16'd0;
    else if (pick == 1) qd = 16'($urandom);
    else qd = 16'($urandom_range(1, 3));
    nq = (qd > 3) ? $urandom_range(1, 3) : int'(qd);

    frame.delete();
    put_header(qd);
    for (int q = 0; q < nq; q++) begin
      if (shape == MSG_TOO_LONG && q == nq - 1) begin
        repeat (5) put_label($urandom_range(50, 63));
        break;
      end
      labels = (shape == MSG_POINTER && q == nq - 1) ? $urandom_range(0, 2)
                                                      : $urandom_range(0, 4);
      repeat (labels) put_label(($urandom_range(0, 9) == 0) ? 63 : $urandom_range(1, 8));
      if (shape == MSG_POINTER && q == nq - 1) begin
        put_byte(8'($urandom_range(64, 255)));
        break;
      end
      put_name_end();
    end

    send_quiet = ($urandom_range(0, 3) == 0);
    case (shape)
      MSG_TRUNCATED: begin
        end_at = $urandom_range(0, frame.size() - 1);
      end
      MSG_RESTART: begin
        cut = $urandom_range(1, frame.size());
        while (frame.size() > cut) void'(frame.pop_back());
        end_at = -1;
      end
      default: begin
        end_at = ($urandom_range(0, 3) == 0) ? -1 : frame.size() - 1;
      end
    endcase
    send_frame(end_at);

    // Stray bytes between messages
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, 1'($urandom));
    end
  endtask

  initial begin
    int target;
    board = new();
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_parse_questions(1'b1);

    // All-ones header: huge question count, message ends with the header
    frame.delete();
    put_fill(8'hFF, 12);
    send_frame(11);
    // All-zeros header: no questions
    frame.delete();
    put_fill(8'h00, 12);
    send_frame(11);
    // Two labels, end flag on the final tail byte
    frame.delete();
    put_header(16'd1);
    put_label(3);
    put_label(2);
    put_name_end();
    send_frame(frame.size() - 1);
    // Root name, then a one-label name, no end flag
    frame.delete();
    put_header(16'd2);
    put_name_end();
    put_label(1);
    put_name_end();
    send_frame(-1);
    // Compression pointer after a label
    frame.delete();
    put_header(16'd1);
    put_label(2);
    put_byte(8'hC0);
    put_byte(8'h0C);
    send_frame(-1);
    // Smallest reserved label length
    frame.delete();
    put_header(16'd1);
    put_byte(8'd64);
    send_frame(-1);
    // End flag inside the tail of the last question
    frame.delete();
    put_header(16'd1);
    put_label(4);
    put_name_end();
    send_frame(frame.size() - 3);
    // Restart inside the header
    frame.delete();
    put_header(16'd1);
    while (frame.size() > 5) void'(frame.pop_back());
    send_frame(-1);
    // Longest legal name, then a name one byte over the limit
    frame.delete();
    put_header(16'd2);
    repeat (3) put_label(63);
    put_label(61);
    put_name_end();
    repeat (3) put_label(63);
    put_label(62);
    send_frame(-1);
    // Start and end on one byte
    frame.delete();
    put_byte(8'h5A);
    send_frame(0);
    // Bytes while idle
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'h00, 1'b0, 1'b0);

    // Header only: questions are not walked
    settle();
    write_parse_questions(1'b0);
    frame.delete();
    put_header(16'd3);
    put_label(2);
    put_name_end();
    send_frame(frame.size() - 1);
    frame.delete();
    put_header(16'd1);
    send_frame(7);

    // Random messages under alternating settings
    foreach (phase_setting[p]) begin
      settle();
      write_parse_questions(phase_setting[p]);
      if (phase_setting[p]) long_hold_armed = 1'b1;
      target = bytes_sent + phase_budget[p];
      while (bytes_sent < target) send_random_message();
    end

    settle();
    $display("covered %0d request bytes (%0d inside messages) in %0d messages",
             bytes_sent, board.bytes_parsed, messages_sent);
    $display("%0d results checked, %0d long holds", board.results_checked, long_holds_done);
    $display("kinds seen: header %0d char %0d name end %0d short %0d pointer %0d too long %0d",
             board.kind_seen[KIND_HEADER], board.kind_seen[KIND_CHAR],
             board.kind_seen[KIND_NAME_END], board.kind_seen[KIND_SHORT],
             board.kind_seen[KIND_POINTER], board.kind_seen[KIND_TOO_LONG]);
    if (board.mismatches == 0 && board.pending_results.size() == 0) begin
      $display("tb_dns_query_header_name_parser: PASS");
    end else begin
      $display("%0d mismatches, %0d results never seen", board.mismatches,
               board.pending_results.size());
      $display("tb_dns_query_header_name_parser: FAIL");
    end
    $finish;
  end
endmodule
